/* hw/rtl/ptb_pkg.sv */
`timescale 1ns / 1ps

package ptb_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int DATA_W         = 32;
    localparam int IDX_W          = 4;
    localparam int CMD_W          = 3;
    localparam int SEL_W          = 7;
    localparam int MAX_REPORTS    = 16;
    localparam int REP_W          = 5;
    localparam int IN_DATA_W      = 40;
    localparam int OUT_DATA_W     = 72;

    localparam logic KIND_EXPIRY = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_LOAD  = 3'd3,
        CMD_RESET = 3'd4,
        CMD_READ  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_TICK_END,
        ST_READ
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] period;
    } t_entry;

endpackage

/* hw/rtl/ptb_store.sv */
`timescale 1ns / 1ps

module ptb_store #(
    parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF,
    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output ptb_pkg::t_entry o_rd_data,
    input  logic            i_cnt_we,
    input  logic            i_per_we,
    input  logic [AW-1:0]   i_wr_addr,
    input  ptb_pkg::t_entry i_wr_data
);
    import ptb_pkg::*;

    logic [DATA_W-1:0]     r_cnt_mem [NUM_TIMERS];
    logic [DATA_W-1:0]     r_per_mem [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_cnt_vld;
    logic [NUM_TIMERS-1:0] r_per_vld;
    logic [DATA_W-1:0]     r_rd_cnt;
    logic [DATA_W-1:0]     r_rd_per;
    logic                  r_rd_cv;
    logic                  r_rd_pv;

    always_ff @(posedge i_clk) begin
        if (i_cnt_we) begin
            r_cnt_mem[i_wr_addr] <= i_wr_data.count;
        end
        if (i_per_we) begin
            r_per_mem[i_wr_addr] <= i_wr_data.period;
        end
        if (i_rd_en) begin
            r_rd_cnt <= r_cnt_mem[i_rd_addr];
            r_rd_per <= r_per_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
            r_per_vld <= '0;
            r_rd_cv   <= 1'b0;
            r_rd_pv   <= 1'b0;
        end else begin
            if (i_cnt_we) begin
                r_cnt_vld[i_wr_addr] <= 1'b1;
            end
            if (i_per_we) begin
                r_per_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_cv <= r_cnt_vld[i_rd_addr];
                r_rd_pv <= r_per_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data.count  = r_rd_cv ? r_rd_cnt : '0;
    assign o_rd_data.period = r_rd_pv ? r_rd_per : '0;

endmodule

/* hw/rtl/periodic_timer_bank.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Content
// s_axis    in         i_s_tvalid / o_s_tready   tuser command, tdata index and period
// m_axis    out        o_m_tvalid / i_m_tready   tuser kind, tdata result, tlast last
//
// A tick walks the timer entries through one shared update unit, one entry per
// cycle unless stalled, then waits in ST_TICK_END for any pending expiry to move
// out. A read waits in ST_READ for the output; other commands finish in ST_IDLE.
// Reset clears the run flags and marks every count and period entry as zero. A
// full output register holds the walk only when a second expiry needs to move out.

module periodic_timer_bank #(
    parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [3:0] timer_index, [35:4] period, [39:36] zero
    input  logic [ptb_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // [2:0] command
    input  logic [ptb_pkg::CMD_W-1:0]        i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [3:0] result_index, [35:4] count_value, [67:36] period_value,
    // [68] running, [71:69] zero
    output logic [ptb_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // [0] result_kind
    output logic                             o_m_tuser,
    output logic                             o_m_tlast
);
    import ptb_pkg::*;

    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    t_state                r_state, n_state;
    logic [AW-1:0]         r_idx, n_idx;
    logic [REP_W-1:0]      r_nrep, n_nrep;
    logic                  r_pend_vld, n_pend_vld;
    logic [IDX_W-1:0]      r_pend_idx, n_pend_idx;
    logic [DATA_W-1:0]     r_pend_per, n_pend_per;
    logic [NUM_TIMERS-1:0] r_run, n_run;
    logic                  r_rd_ok, n_rd_ok;
    logic                  r_rd_run, n_rd_run;
    logic [IDX_W-1:0]      r_rd_index, n_rd_index;
    logic                  r_out_vld, n_out_vld;
    logic                  r_out_kind, n_out_kind;
    logic [IDX_W-1:0]      r_out_idx, n_out_idx;
    logic [DATA_W-1:0]     r_out_cnt, n_out_cnt;
    logic [DATA_W-1:0]     r_out_per, n_out_per;
    logic                  r_out_run, n_out_run;
    logic                  r_out_last, n_out_last;

    t_cmd              cmd;
    logic [IDX_W-1:0]  in_idx;
    logic [DATA_W-1:0] in_val;
    logic [SEL_W-1:0]  in_sel;
    logic [AW-1:0]     in_addr;
    logic              idx_ok;
    logic [SEL_W-1:0]  cur_sel;
    logic              out_free;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    t_entry            rd_data;
    logic              cnt_we;
    logic              per_we;
    logic [AW-1:0]     wr_addr;
    t_entry            wr_data;

    logic [DATA_W-1:0] cnt_inc;
    logic              expire;
    logic              report;
    logic              stall;

    assign cmd      = t_cmd'(i_s_tuser);
    assign in_idx   = i_s_tdata[IDX_W-1:0];
    assign in_val   = i_s_tdata[IDX_W+DATA_W-1:IDX_W];
    assign in_sel   = SEL_W'(in_idx);
    assign in_addr  = in_sel[AW-1:0];
    assign idx_ok   = in_sel < SEL_W'(NUM_TIMERS);
    assign cur_sel  = SEL_W'(r_idx);
    assign out_free = !r_out_vld || i_m_tready;

    assign cnt_inc = rd_data.count + 32'd1;
    assign expire  = r_run[r_idx] && (rd_data.period != '0) && (cnt_inc >= rd_data.period);
    assign report  = expire && (r_nrep < REP_W'(MAX_REPORTS));
    assign stall   = report && r_pend_vld && !out_free;

    ptb_store #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_cnt_we  (cnt_we),
        .i_per_we  (per_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_idx      <= '0;
            r_nrep     <= '0;
            r_pend_vld <= 1'b0;
            r_run      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_nrep     <= n_nrep;
            r_pend_vld <= n_pend_vld;
            r_run      <= n_run;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_pend_per <= n_pend_per;
        r_rd_ok    <= n_rd_ok;
        r_rd_run   <= n_rd_run;
        r_rd_index <= n_rd_index;
        r_out_kind <= n_out_kind;
        r_out_idx  <= n_out_idx;
        r_out_cnt  <= n_out_cnt;
        r_out_per  <= n_out_per;
        r_out_run  <= n_out_run;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_nrep     = r_nrep;
        n_pend_vld = r_pend_vld;
        n_pend_idx = r_pend_idx;
        n_pend_per = r_pend_per;
        n_run      = r_run;
        n_rd_ok    = r_rd_ok;
        n_rd_run   = r_rd_run;
        n_rd_index = r_rd_index;
        n_out_vld  = r_out_vld && !i_m_tready;
        n_out_kind = r_out_kind;
        n_out_idx  = r_out_idx;
        n_out_cnt  = r_out_cnt;
        n_out_per  = r_out_per;
        n_out_run  = r_out_run;
        n_out_last = r_out_last;
        rd_en      = 1'b0;
        rd_addr    = r_idx;
        cnt_we     = 1'b0;
        per_we     = 1'b0;
        wr_addr    = r_idx;
        wr_data    = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    case (cmd)
                        CMD_TICK: begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            n_idx      = '0;
                            n_nrep     = '0;
                            n_pend_vld = 1'b0;
                            n_state    = ST_TICK;
                        end
                        CMD_START: begin
                            if (idx_ok) begin
                                n_run[in_addr] = 1'b1;
                                cnt_we         = 1'b1;
                                wr_addr        = in_addr;
                            end
                        end
                        CMD_STOP: begin
                            if (idx_ok) begin
                                n_run[in_addr] = 1'b0;
                            end
                        end
                        CMD_LOAD: begin
                            if (idx_ok && in_val != '0) begin
                                cnt_we         = 1'b1;
                                per_we         = 1'b1;
                                wr_addr        = in_addr;
                                wr_data.period = in_val;
                            end
                        end
                        CMD_RESET: begin
                            if (idx_ok) begin
                                cnt_we  = 1'b1;
                                wr_addr = in_addr;
                            end
                        end
                        CMD_READ: begin
                            rd_en      = 1'b1;
                            rd_addr    = in_addr;
                            n_rd_ok    = idx_ok;
                            n_rd_run   = idx_ok ? r_run[in_addr] : 1'b0;
                            n_rd_index = in_idx;
                            n_state    = ST_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_TICK: begin
                if (!stall) begin
                    if (r_run[r_idx]) begin
                        cnt_we        = 1'b1;
                        wr_addr       = r_idx;
                        wr_data.count = expire ? '0 : cnt_inc;
                    end
                    if (report) begin
                        if (r_pend_vld) begin
                            n_out_vld  = 1'b1;
                            n_out_kind = KIND_EXPIRY;
                            n_out_idx  = r_pend_idx;
                            n_out_cnt  = '0;
                            n_out_per  = r_pend_per;
                            n_out_run  = 1'b1;
                            n_out_last = 1'b0;
                        end
                        n_pend_vld = 1'b1;
                        n_pend_idx = cur_sel[IDX_W-1:0];
                        n_pend_per = rd_data.period;
                        n_nrep     = r_nrep + 1'b1;
                    end
                    if (r_idx == AW'(NUM_TIMERS - 1)) begin
                        n_state = ST_TICK_END;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        rd_en   = 1'b1;
                        rd_addr = r_idx + 1'b1;
                    end
                end
            end
            ST_TICK_END: begin
                if (!r_pend_vld) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_kind = KIND_EXPIRY;
                    n_out_idx  = r_pend_idx;
                    n_out_cnt  = '0;
                    n_out_per  = r_pend_per;
                    n_out_run  = 1'b1;
                    n_out_last = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            ST_READ: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_kind = KIND_READ;
                    n_out_idx  = r_rd_index;
                    n_out_cnt  = r_rd_ok ? rd_data.count : '0;
                    n_out_per  = r_rd_ok ? rd_data.period : '0;
                    n_out_run  = r_rd_run;
                    n_out_last = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {3'b000, r_out_run, r_out_per, r_out_cnt, r_out_idx};

endmodule

/* verif/tb_periodic_timer_bank.sv */
`timescale 1ns / 1ps

import ptb_pkg::*;

typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] period;
    logic              running;
    logic              last;
} t_timer_result;

class timer_bank_scoreboard;
    logic [DATA_W-1:0] counts [NUM_TIMERS_DEF];
    logic [DATA_W-1:0] periods [NUM_TIMERS_DEF];
    bit                run_flags [NUM_TIMERS_DEF];
    t_timer_result     expected_q [$];
    int                errors;

    function new();
        for (int i = 0; i < NUM_TIMERS_DEF; i++) begin
            counts[i] = '0;
            periods[i] = '0;
            run_flags[i] = 1'b0;
        end
        errors = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    task report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Advances the timer bank by one accepted command and queues the results it causes.
    task note_input(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        int            fired [MAX_REPORTS];
        int            n_fired;
        bit            addr_ok;
        t_timer_result res;
        n_fired = 0;
        addr_ok = int'(idx) < NUM_TIMERS_DEF;
        case (cmd)
            CMD_TICK: begin
                for (int i = 0; i < NUM_TIMERS_DEF; i++) begin
                    if (run_flags[i]) begin
                        counts[i] = counts[i] + 32'd1;
                        if (periods[i] != '0 && counts[i] >= periods[i]) begin
                            counts[i] = '0;
                            if (n_fired < MAX_REPORTS) begin
                                fired[n_fired] = i;
                                n_fired++;
                            end
                        end
                    end
                end
                for (int k = 0; k < n_fired; k++) begin
                    res.kind = KIND_EXPIRY;
                    res.index = IDX_W'(fired[k]);
                    res.count = '0;
                    res.period = periods[fired[k]];
                    res.running = 1'b1;
                    res.last = (k == n_fired - 1);
                    expected_q.push_back(res);
                end
            end
            CMD_START: begin
                if (addr_ok) begin
                    run_flags[idx] = 1'b1;
                    counts[idx] = '0;
                end
            end
            CMD_STOP: begin
                if (addr_ok) begin
                    run_flags[idx] = 1'b0;
                end
            end
            CMD_LOAD: begin
                if (addr_ok && val != '0) begin
                    periods[idx] = val;
                    counts[idx] = '0;
                end
            end
            CMD_RESET: begin
                if (addr_ok) begin
                    counts[idx] = '0;
                end
            end
            CMD_READ: begin
                res.kind = KIND_READ;
                res.index = idx;
                res.count = addr_ok ? counts[idx] : '0;
                res.period = addr_ok ? periods[idx] : '0;
                res.running = addr_ok ? run_flags[idx] : 1'b0;
                res.last = 1'b1;
                expected_q.push_back(res);
            end
            default: begin
            end
        endcase
    endtask

    task check_result(logic kind, logic [OUT_DATA_W-1:0] data, logic last);
        t_timer_result want;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction, kind %0d index %0d",
                                      kind, data[3:0]));
            return;
        end
        want = expected_q.pop_front();
        if (kind !== want.kind) begin
            report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
        end
        if (data[3:0] !== want.index) begin
            report_mismatch($sformatf("index %0d, expected %0d", data[3:0], want.index));
        end
        if (data[35:4] !== want.count) begin
            report_mismatch($sformatf("timer %0d count %h, expected %h",
                                      want.index, data[35:4], want.count));
        end
        if (data[67:36] !== want.period) begin
            report_mismatch($sformatf("timer %0d period %h, expected %h",
                                      want.index, data[67:36], want.period));
        end
        if (data[68] !== want.running) begin
            report_mismatch($sformatf("timer %0d running %0d, expected %0d",
                                      want.index, data[68], want.running));
        end
        if (data[71:69] !== 3'b000) begin
            report_mismatch($sformatf("padding bits %b, expected zero", data[71:69]));
        end
        if (last !== want.last) begin
            report_mismatch($sformatf("timer %0d last %0d, expected %0d",
                                      want.index, last, want.last));
        end
    endtask

    task final_check();
        if (expected_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
        end
    endtask
endclass

module tb_periodic_timer_bank;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_ITEMS = 136;
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [CMD_W-1:0]      s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    bit hold_req = 1'b0;
    int calm_tx = 0;
    int calm_rx = 0;
    int items_sent = 0;
    int idle_cycles = 0;

    timer_bank_scoreboard board;

    always #6 clk = ~clk;

    periodic_timer_bank DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    function automatic int pick_gap(input bit rx_side);
        int r;
        if (rx_side && calm_rx > 0) begin
            calm_rx--;
            return 0;
        end
        if (!rx_side && calm_tx > 0) begin
            calm_tx--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            if (rx_side) begin
                calm_rx = $urandom_range(20, 60);
            end else begin
                calm_tx = $urandom_range(10, 30);
            end
            return 0;
        end
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DATA_W-1:0] pick_period();
        case ($urandom_range(0, 9))
            0: return '0;
            1, 2: return $urandom();
            3: return $urandom_range(7, 300);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] val);
        int gap;
        gap = pick_gap(1'b0);
        if (gap > 0) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0000, val, idx};
        s_tuser <= cmd;
        do @(posedge clk); while (!s_tready);
        board.note_input(cmd, idx, val);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
    endtask

    task automatic random_item();
        int r;
        logic [CMD_W-1:0] cmd;
        r = $urandom_range(0, 99);
        if (r < 35) cmd = CMD_TICK;
        else if (r < 50) cmd = CMD_START;
        else if (r < 58) cmd = CMD_STOP;
        else if (r < 72) cmd = CMD_LOAD;
        else if (r < 79) cmd = CMD_RESET;
        else if (r < 94) cmd = CMD_READ;
        else if (r < 97) cmd = CMD_SPARE6;
        else cmd = CMD_SPARE7;
        send_item(cmd, IDX_W'($urandom()), (cmd == CMD_LOAD) ? pick_period() : $urandom());
    endtask

    task automatic run_directed();
        send_item(CMD_READ, 4'd0, 32'h0000_0000);
        send_item(CMD_TICK, 4'd15, 32'hFFFF_FFFF);
        send_item(CMD_LOAD, 4'd0, 32'd1);
        send_item(CMD_START, 4'd0, 32'd0);
        send_item(CMD_TICK, 4'd0, 32'd0);
        send_item(CMD_READ, 4'd0, 32'd0);
        send_item(CMD_LOAD, 4'd15, 32'hFFFF_FFFF);
        send_item(CMD_START, 4'd15, 32'hFFFF_FFFF);
        send_item(CMD_TICK, 4'd0, 32'd0);
        send_item(CMD_READ, 4'd15, 32'd0);
        send_item(CMD_LOAD, 4'd15, 32'd0);
        send_item(CMD_READ, 4'd15, 32'd0);
        send_item(CMD_RESET, 4'd15, 32'd0);
        send_item(CMD_READ, 4'd15, 32'd0);
        send_item(CMD_START, 4'd3, 32'd0);
        send_item(CMD_TICK, 4'd0, 32'd0);
        send_item(CMD_READ, 4'd3, 32'd0);
        send_item(CMD_STOP, 4'd0, 32'd0);
        send_item(CMD_TICK, 4'd0, 32'd0);
        send_item(CMD_READ, 4'd0, 32'd0);
        send_item(CMD_SPARE6, 4'd15, 32'hFFFF_FFFF);
        send_item(CMD_SPARE7, 4'd9, 32'h5A5A_A5A5);
        send_item(CMD_LOAD, 4'd2, 32'h8000_0000);
        send_item(CMD_READ, 4'd2, 32'hFFFF_FFFF);
    endtask

    // Every timer expires on the same tick while the receiver holds off.
    task automatic all_timers_burst();
        for (int i = 0; i < NUM_TIMERS_DEF; i++) begin
            send_item(CMD_LOAD, IDX_W'(i), 32'd1);
            send_item(CMD_START, IDX_W'(i), $urandom());
        end
        hold_req = 1'b1;
        repeat (4) send_item(CMD_TICK, IDX_W'($urandom()), $urandom());
        send_item(CMD_READ, IDX_W'($urandom()), $urandom());
    endtask

    task automatic run_random();
        int first;
        int n_ticks;
        bit burst_done;
        bit pause_done;
        logic [IDX_W-1:0] idx;
        first = items_sent;
        burst_done = 1'b0;
        pause_done = 1'b0;
        while (items_sent - first < RANDOM_ITEMS) begin
            if (!burst_done && items_sent - first >= 50) begin
                all_timers_burst();
                burst_done = 1'b1;
            end else if (!pause_done && items_sent - first >= 110) begin
                wait_drained();
                pause_done = 1'b1;
            end else begin
                case ($urandom_range(0, 9))
                    6, 7, 8: begin
                        idx = IDX_W'($urandom());
                        send_item(CMD_LOAD, idx, $urandom_range(1, 5));
                        send_item(CMD_START, idx, $urandom());
                        n_ticks = $urandom_range(1, 6);
                        repeat (n_ticks) send_item(CMD_TICK, IDX_W'($urandom()), $urandom());
                        send_item(CMD_READ, idx, $urandom());
                    end
                    default: random_item();
                endcase
            end
        end
    endtask

    initial begin
        int stall;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end else begin
                stall = pick_gap(1'b1);
                if (stall == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    repeat (stall - 1) @(negedge clk);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            board.check_result(m_tuser, m_tdata, m_tlast);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        board = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        run_directed();
        wait_drained();
        run_random();
        wait_drained();
        repeat (2 * NUM_TIMERS_DEF + 8) @(posedge clk);
        board.final_check();
        if (board.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
